// ----- rtl/ptb_pkg.sv -----
// Shared types and constants for the periodic timer bank.
`timescale 1ns / 1ps
`default_nettype none
package ptb_pkg;

  localparam int SLOTS   = 16;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int TIME_W  = 16;
  localparam int SLOT_W  = 4;
  localparam int STAT_W  = 2;

  localparam logic [STAT_W-1:0] ST_ADDED = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FIRED = 2'd2;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [0:0] REG_TICK_STEP = 1'b0;
  localparam logic [TIME_W-1:0] TICK_STEP_RESET = 16'd10;

  typedef struct packed {
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] remain;
  } ptb_entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } ptb_cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/ptb_cell.sv -----
// One timer slot of the ring: holds a period and a remaining time.
`timescale 1ns / 1ps
`default_nettype none
module ptb_cell (
  input  wire                       clk_i,
  input  ptb_pkg::ptb_cell_ctrl_t   ctrl_i,
  input  ptb_pkg::ptb_entry_t       shift_i,
  input  wire [ptb_pkg::TIME_W-1:0] period_i,
  output ptb_pkg::ptb_entry_t       entry_o
);
  import ptb_pkg::*;

  ptb_entry_t entry_q;
  ptb_entry_t entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load) begin
      entry_d.period = period_i;
      entry_d.remain = period_i;
    end else if (ctrl_i.shift) begin
      entry_d = shift_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

// ----- rtl/ptb_head.sv -----
// Update unit at the head of the ring: saturating countdown, fire detect and reload.
`timescale 1ns / 1ps
`default_nettype none
module ptb_head (
  input  ptb_pkg::ptb_entry_t       entry_i,
  input  wire [ptb_pkg::TIME_W-1:0] tick_step_i,
  input  wire                       active_i,
  output ptb_pkg::ptb_entry_t       entry_o,
  output logic                      fire_o
);
  import ptb_pkg::*;

  logic [TIME_W-1:0] dec;

  always_comb begin
    dec     = (entry_i.remain > tick_step_i) ? (entry_i.remain - tick_step_i) : '0;
    fire_o  = active_i && (dec == '0);
    entry_o = entry_i;
    if (active_i) begin
      entry_o.remain = fire_o ? entry_i.period : dec;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/periodic_timer_bank.sv -----
// Top level of the periodic timer bank: control, output register, config port and cell ring.
// An add beat gives its one result in the output register in the cycle after it is accepted.
// A tick beat is accepted in idle, rotates the ring past the head unit, one slot per cycle unless a
// fired result waits on a stalled output register, and closes out the last fired result in a flush state.
// Fired results leave in slot order; the next beat is accepted once the previous one is done.
// Reset clears the active count and sets tick_step to 10; slot contents are undefined until added.
`timescale 1ns / 1ps
`default_nettype none
module periodic_timer_bank (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire                          in_op_i,
  input  wire  [ptb_pkg::TIME_W-1:0]   in_period_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [ptb_pkg::STAT_W-1:0]   out_status_o,
  output logic [ptb_pkg::SLOT_W-1:0]   out_slot_o,
  output logic                         out_last_o,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [2:0]                   paddr,
  input  wire  [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import ptb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FLUSH
  } state_e;

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    walk_q, walk_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                pend_valid_q, pend_valid_d;
  logic [SLOT_W-1:0]   pend_slot_q, pend_slot_d;
  logic                out_valid_q, out_valid_d;
  logic [STAT_W-1:0]   out_status_q, out_status_d;
  logic [SLOT_W-1:0]   out_slot_q, out_slot_d;
  logic                out_last_q, out_last_d;
  logic [TIME_W-1:0]   tick_step_q, tick_step_d;

  logic                out_free;
  logic                accept;
  logic                out_load;
  logic                shift;
  logic                add_load;
  logic                need_emit;
  logic                head_active;
  logic                fire;
  logic                cfg_we;

  ptb_entry_t          entry   [SLOTS];
  ptb_entry_t          shin    [SLOTS];
  ptb_entry_t          head_out;

  assign head_active = (CNT_W'(walk_q) < count_q) && (state_q == S_WALK);

  ptb_head u_head (
    .entry_i     (entry[0]),
    .tick_step_i (tick_step_q),
    .active_i    (head_active),
    .entry_o     (head_out),
    .fire_o      (fire)
  );

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    ptb_cell_ctrl_t ctrl;
    if (k == SLOTS - 1) begin : g_tail
      assign shin[k] = head_out;
    end else begin : g_mid
      assign shin[k] = entry[k+1];
    end
    assign ctrl.shift = shift;
    assign ctrl.load  = add_load && (count_q[IDX_W-1:0] == IDX_W'(k));
    ptb_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .shift_i  (shin[k]),
      .period_i (in_period_i),
      .entry_o  (entry[k])
    );
  end

  assign cfg_we = psel && penable && pwrite && pready && (paddr[2:2] == REG_TICK_STEP);
  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == REG_TICK_STEP) ? {16'd0, tick_step_q} : 32'd0;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign need_emit  = fire && pend_valid_q;

  always_comb begin
    state_d      = state_q;
    walk_d       = walk_q;
    count_d      = count_q;
    pend_valid_d = pend_valid_q;
    pend_slot_d  = pend_slot_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_last_d   = out_last_q;
    tick_step_d  = cfg_we ? pwdata[TIME_W-1:0] : tick_step_q;
    out_load     = 1'b0;
    shift        = 1'b0;
    add_load     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_op_i == OP_ADD) begin
            out_load   = 1'b1;
            out_last_d = 1'b1;
            if (count_q >= CNT_W'(SLOTS)) begin
              out_status_d = ST_FULL;
              out_slot_d   = '0;
            end else begin
              out_status_d = ST_ADDED;
              out_slot_d   = SLOT_W'(count_q);
              add_load     = 1'b1;
              count_d      = count_q + 1'b1;
            end
          end else begin
            state_d      = S_WALK;
            walk_d       = '0;
            pend_valid_d = 1'b0;
          end
        end
      end
      S_WALK: begin
        if (!need_emit || out_free) begin
          shift = 1'b1;
          if (need_emit) begin
            out_load     = 1'b1;
            out_status_d = ST_FIRED;
            out_slot_d   = pend_slot_q;
            out_last_d   = 1'b0;
          end
          if (fire) begin
            pend_valid_d = 1'b1;
            pend_slot_d  = SLOT_W'(walk_q);
          end
          if (walk_q == IDX_W'(SLOTS - 1)) begin
            state_d = S_FLUSH;
          end else begin
            walk_d = walk_q + 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_load     = 1'b1;
          out_status_d = ST_FIRED;
          out_slot_d   = pend_slot_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      walk_q       <= '0;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
      pend_slot_q  <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_slot_q   <= '0;
      out_last_q   <= 1'b0;
      tick_step_q  <= TICK_STEP_RESET;
    end else begin
      state_q      <= state_d;
      walk_q       <= walk_d;
      count_q      <= count_d;
      pend_valid_q <= pend_valid_d;
      pend_slot_q  <= pend_slot_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_slot_q   <= out_slot_d;
      out_last_q   <= out_last_d;
      tick_step_q  <= tick_step_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_slot_o   = out_slot_q;
  assign out_last_o   = out_last_q;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(SLOTS))
    else $error("active count above slot count");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("output register overwritten while a beat is stalled");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_valid_q)
    else $error("pending fired result left behind after a tick");

  a_walk_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |=> (count_q == $past(count_q)))
    else $error("active count changed during a tick walk");
`endif

endmodule
`default_nettype wire

// ----- verif/periodic_timer_bank_checker.sv -----
// Checker for the periodic timer bank: predicts the timer results and compares each output beat.
`timescale 1ns / 1ps
`default_nettype none
module periodic_timer_bank_checker (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  input  wire                         in_stall_i,
  input  wire                         in_op_i,
  input  wire [ptb_pkg::TIME_W-1:0]   in_period_i,
  input  wire                         out_valid_i,
  input  wire                         out_stall_i,
  input  wire [ptb_pkg::STAT_W-1:0]   out_status_i,
  input  wire [ptb_pkg::SLOT_W-1:0]   out_slot_i,
  input  wire                         out_last_i,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire [2:0]                   paddr,
  input  wire [31:0]                  pwdata,
  input  wire [31:0]                  prdata,
  input  wire                         pready,
  output int                          fail_count_o,
  output int                          events_due_o
);
  import ptb_pkg::*;

  localparam logic [2:0] TICK_STEP_ADDR = {REG_TICK_STEP, 2'b00};

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } timer_event_t;

  logic [TIME_W-1:0] period_mem [SLOTS];
  logic [TIME_W-1:0] remain_mem [SLOTS];
  logic [CNT_W-1:0]  active_q;
  logic [TIME_W-1:0] tick_step_q;
  timer_event_t      timer_events_due [$];
  int                mismatches = 0;
  int                due_count = 0;

  assign fail_count_o = mismatches;
  assign events_due_o = due_count;

  task automatic step_timers(input logic op, input logic [TIME_W-1:0] period);
    timer_event_t      fired [$];
    timer_event_t      ev;
    logic [TIME_W-1:0] left;
    if (op == OP_ADD) begin
      if (active_q >= SLOTS) begin
        ev.status = ST_FULL;
        ev.slot   = '0;
      end else begin
        period_mem[active_q[IDX_W-1:0]] = period;
        remain_mem[active_q[IDX_W-1:0]] = period;
        ev.status = ST_ADDED;
        ev.slot   = SLOT_W'(active_q);
        active_q  = active_q + 1'b1;
      end
      ev.last = 1'b1;
      timer_events_due.push_back(ev);
    end else begin
      for (int i = 0; i < int'(active_q); i++) begin
        left = remain_mem[i];
        left = (left > tick_step_q) ? left - tick_step_q : '0;
        if (left == '0) begin
          ev.status = ST_FIRED;
          ev.slot   = SLOT_W'(i);
          ev.last   = 1'b0;
          fired.push_back(ev);
          left = period_mem[i];
        end
        remain_mem[i] = left;
      end
      if (fired.size() > 0) fired[fired.size()-1].last = 1'b1;
      foreach (fired[k]) timer_events_due.push_back(fired[k]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    timer_event_t want;
    if (!rst_ni) begin
      active_q    = '0;
      tick_step_q = TICK_STEP_RESET;
      timer_events_due.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (timer_events_due.size() == 0) begin
          $error("unexpected beat: status %0d slot %0d last %0d",
                 out_status_i, out_slot_i, out_last_i);
          mismatches++;
        end else begin
          want = timer_events_due.pop_front();
          if (out_status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status_i);
            mismatches++;
          end
          if (out_slot_i !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, out_slot_i);
            mismatches++;
          end
          if (out_last_i !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_last_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) step_timers(in_op_i, in_period_i);
      if (psel && penable && pready && paddr == TICK_STEP_ADDR) begin
        if (pwrite) begin
          tick_step_q = pwdata[TIME_W-1:0];
        end else if (prdata !== 32'(tick_step_q)) begin
          $error("prdata: expected %0d, got %0d", tick_step_q, prdata);
          mismatches++;
        end
      end
    end
    due_count = timer_events_due.size();
  end

endmodule
`default_nettype wire

// ----- verif/periodic_timer_bank_tb.sv -----
// Testbench top for the periodic timer bank: clock, reset, stimulus, config writes and verdict.
`timescale 1ns / 1ps
`default_nettype none
module periodic_timer_bank_tb;
  import ptb_pkg::*;

  localparam int          CYCLE_LIMIT    = 400000;
  localparam int          SETTLE_CYCLES  = 20;
  localparam int          PHASE_BEATS    = 57;
  localparam logic [2:0]  TICK_STEP_ADDR = {REG_TICK_STEP, 2'b00};

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              in_op_i = OP_TICK;
  logic [TIME_W-1:0] in_period_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [STAT_W-1:0] out_status_o;
  logic [SLOT_W-1:0] out_slot_o;
  logic              out_last_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int fail_count;
  int events_due;
  int cycle_count = 0;
  int stall_left = 0;
  bit idle_on = 1'b1;

  periodic_timer_bank DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_op_i      (in_op_i),
    .in_period_i  (in_period_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_status_o (out_status_o),
    .out_slot_o   (out_slot_o),
    .out_last_o   (out_last_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  periodic_timer_bank_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_op_i      (in_op_i),
    .in_period_i  (in_period_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_status_i (out_status_o),
    .out_slot_i   (out_slot_o),
    .out_last_i   (out_last_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .events_due_o (events_due)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 4);
    end
    out_stall_i <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL periodic_timer_bank");
      $finish;
    end
  end

  function automatic logic [TIME_W-1:0] pick_period();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return TIME_W'($urandom_range(1, 64));
      3:       return TIME_W'($urandom_range(1, 1000));
      default: return TIME_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_beat(input logic op, input logic [TIME_W-1:0] period);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_op_i     <= op;
    in_period_i <= period;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (events_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes the tick step, then reads it back so the checker can compare prdata.
  task automatic program_tick_step(input logic [TIME_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TICK_STEP_ADDR;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input logic [TIME_W-1:0] step);
    logic op;
    drain();
    program_tick_step(step);
    repeat (PHASE_BEATS) begin
      op = ($urandom_range(0, 6) == 0) ? OP_ADD : OP_TICK;
      send_beat(op, (op == OP_ADD) ? pick_period() : TIME_W'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A tick on an empty bank, then zero, maximum and ordinary periods at the reset step.
    send_beat(OP_TICK, '1);
    send_beat(OP_ADD, '0);
    send_beat(OP_ADD, '1);
    send_beat(OP_ADD, 16'd25);
    repeat (3) send_beat(OP_TICK, '0);

    // The largest step fires every timer at once.
    drain();
    program_tick_step('1);
    repeat (2) send_beat(OP_TICK, 16'h5A5A);

    // A zero step only fires timers that already sit at zero.
    drain();
    program_tick_step('0);
    repeat (2) send_beat(OP_TICK, 16'hA5A5);

    drain();
    program_tick_step(16'd1);
    send_beat(OP_ADD, 16'd1);
    repeat (2) send_beat(OP_TICK, '0);

    run_phase(TICK_STEP_RESET);
    run_phase(16'd1);
    run_phase('1);
    run_phase('0);
    run_phase(TIME_W'($urandom_range(2, 300)));
    run_phase(TIME_W'($urandom_range(1, 65535)));
    drain();
    idle_on = 1'b0;
    run_phase(16'd3);
    drain();

    if (fail_count == 0) begin
      $display("PASS periodic_timer_bank");
    end else begin
      $display("FAIL periodic_timer_bank");
    end
    $finish;
  end

endmodule
`default_nettype wire
